### sv/lsoa_pkg.sv
// Shared types and constants for the lidar sector obstacle avoider.
package lsoa_pkg;

   localparam int IDX_W        = 10;
   localparam int RANGE_W      = 16;
   localparam int SCAN_SAMPLES = 1024;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_START = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_END   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_RANGE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_RANGE   = 3'd5;

   localparam logic [IDX_W-1:0]   LEFT_LOW_RESET     = 10'd192;
   localparam logic [IDX_W-1:0]   CENTER_START_RESET = 10'd384;
   localparam logic [IDX_W-1:0]   CENTER_END_RESET   = 10'd640;
   localparam logic [IDX_W-1:0]   RIGHT_HIGH_RESET   = 10'd832;
   localparam logic [RANGE_W-1:0] SAFE_RANGE_RESET   = 16'd1000;
   localparam logic [RANGE_W-1:0] STOP_RANGE_RESET   = 16'd500;

   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0]   left_low_index;
      logic [IDX_W-1:0]   center_start_index;
      logic [IDX_W-1:0]   center_end_index;
      logic [IDX_W-1:0]   right_high_index;
      logic [RANGE_W-1:0] safe_range;
      logic [RANGE_W-1:0] stop_range;
   } cfg_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_value;
      logic               in_center;
      logic               in_left;
      logic               in_right;
      logic               last_sample;
   } item_type;

   typedef struct packed {
      logic               keep_moving;
      logic               turning;
      logic               turn_left;
      logic               turn_right;
      logic               drive_forward;
      logic [1:0]         turn_direction;
      logic [RANGE_W-1:0] center_closest;
      logic [RANGE_W-1:0] left_closest;
      logic [RANGE_W-1:0] right_closest;
   } rsp_type;

endpackage

### sv/lsoa_req_if.sv
// Request channel: one range sample with its index and end-of-scan mark.
interface lsoa_req_if;
   logic                        valid;
   logic                        ready;
   logic [lsoa_pkg::IDX_W-1:0]   sample_index;
   logic [lsoa_pkg::RANGE_W-1:0] range_value;
   logic                        last_sample;

   modport source (output valid, output sample_index, output range_value,
                   output last_sample, input ready);
   modport sink (input valid, input sample_index, input range_value,
                 input last_sample, output ready);
endinterface

### sv/lsoa_rsp_if.sv
// Response channel: one drive command per scan.
interface lsoa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        keep_moving;
   logic                        turning;
   logic                        turn_left;
   logic                        turn_right;
   logic                        drive_forward;
   logic [1:0]                  turn_direction;
   logic [lsoa_pkg::RANGE_W-1:0] center_closest;
   logic [lsoa_pkg::RANGE_W-1:0] left_closest;
   logic [lsoa_pkg::RANGE_W-1:0] right_closest;

   modport source (output valid, output keep_moving, output turning,
                   output turn_left, output turn_right, output drive_forward,
                   output turn_direction, output center_closest,
                   output left_closest, output right_closest, input ready);
   modport sink (input valid, input keep_moving, input turning,
                 input turn_left, input turn_right, input drive_forward,
                 input turn_direction, input center_closest,
                 input left_closest, input right_closest, output ready);
endinterface

### sv/lsoa_csr.sv
// Configuration register file for window bounds and range thresholds.
module lsoa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lsoa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lsoa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lsoa_pkg::cfg_type                   cfg
);

   lsoa_pkg::cfg_type cfg_ff;
   lsoa_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lsoa_pkg::CSR_LEFT_LOW:
               cfg_in.left_low_index = csr_wdata[lsoa_pkg::IDX_W-1:0];
            lsoa_pkg::CSR_CENTER_START:
               cfg_in.center_start_index = csr_wdata[lsoa_pkg::IDX_W-1:0];
            lsoa_pkg::CSR_CENTER_END:
               cfg_in.center_end_index = csr_wdata[lsoa_pkg::IDX_W-1:0];
            lsoa_pkg::CSR_RIGHT_HIGH:
               cfg_in.right_high_index = csr_wdata[lsoa_pkg::IDX_W-1:0];
            lsoa_pkg::CSR_SAFE_RANGE:
               cfg_in.safe_range = csr_wdata[lsoa_pkg::RANGE_W-1:0];
            lsoa_pkg::CSR_STOP_RANGE:
               cfg_in.stop_range = csr_wdata[lsoa_pkg::RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_low_index     <= lsoa_pkg::LEFT_LOW_RESET;
         cfg_ff.center_start_index <= lsoa_pkg::CENTER_START_RESET;
         cfg_ff.center_end_index   <= lsoa_pkg::CENTER_END_RESET;
         cfg_ff.right_high_index   <= lsoa_pkg::RIGHT_HIGH_RESET;
         cfg_ff.safe_range         <= lsoa_pkg::SAFE_RANGE_RESET;
         cfg_ff.stop_range         <= lsoa_pkg::STOP_RANGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/lsoa_front.sv
// Front end: accept samples and tag each with its window membership.
module lsoa_front (
   lsoa_req_if.sink                  req_chan,
   input  lsoa_pkg::cfg_type         cfg,
   input  logic                      queue_full,
   output logic                      push,
   output lsoa_pkg::item_type        push_item
);

   logic in_scan;
   logic on_start;
   logic on_end;

   always_comb begin
      in_scan  = 32'(req_chan.sample_index) < lsoa_pkg::SCAN_SAMPLES;
      on_start = req_chan.sample_index == cfg.center_start_index;
      on_end   = req_chan.sample_index == cfg.center_end_index;

      push_item.range_value = req_chan.range_value;
      push_item.last_sample = req_chan.last_sample;
      push_item.in_center   = in_scan && (on_start ||
         (req_chan.sample_index >= cfg.center_start_index &&
          req_chan.sample_index <= cfg.center_end_index));
      push_item.in_left     = in_scan && (on_start ||
         (req_chan.sample_index >= cfg.left_low_index &&
          req_chan.sample_index <= cfg.center_start_index));
      push_item.in_right    = in_scan && (on_end ||
         (req_chan.sample_index >= cfg.center_end_index &&
          req_chan.sample_index <= cfg.right_high_index));
   end

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

endmodule

### sv/lsoa_queue.sv
// Short register queue between the front and back ends.
module lsoa_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lsoa_pkg::item_type   push_item,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output lsoa_pkg::item_type   head_item
);

   lsoa_pkg::item_type               mem_ff [lsoa_pkg::QUEUE_DEPTH];
   logic [lsoa_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [lsoa_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [lsoa_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [lsoa_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [lsoa_pkg::QCNT_W-1:0]      count_ff;
   logic [lsoa_pkg::QCNT_W-1:0]      count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == lsoa_pkg::QUEUE_DEPTH - 1) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == lsoa_pkg::QUEUE_DEPTH - 1) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = 32'(count_ff) == lsoa_pkg::QUEUE_DEPTH;
   assign not_empty = count_ff != '0;
   assign head_item = mem_ff[rd_ptr_ff];

endmodule

### sv/lsoa_back.sv
// Back end: fold window minimums, decide on scan end, hold the response.
module lsoa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lsoa_pkg::cfg_type    cfg,
   input  logic                 head_valid,
   input  lsoa_pkg::item_type   head_item,
   output logic                 pop,
   lsoa_rsp_if.source           rsp_chan
);

   logic [lsoa_pkg::RANGE_W-1:0] cmin_ff;
   logic [lsoa_pkg::RANGE_W-1:0] cmin_in;
   logic [lsoa_pkg::RANGE_W-1:0] lmin_ff;
   logic [lsoa_pkg::RANGE_W-1:0] lmin_in;
   logic [lsoa_pkg::RANGE_W-1:0] rmin_ff;
   logic [lsoa_pkg::RANGE_W-1:0] rmin_in;
   logic                         left_choice_ff;
   logic                         left_choice_in;
   logic                         right_choice_ff;
   logic                         right_choice_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   lsoa_pkg::rsp_type            rsp_ff;
   lsoa_pkg::rsp_type            rsp_in;

   logic [lsoa_pkg::RANGE_W-1:0] c_fold;
   logic [lsoa_pkg::RANGE_W-1:0] l_fold;
   logic [lsoa_pkg::RANGE_W-1:0] r_fold;
   logic                         turn;
   logic                         below_stop;
   logic                         pick_left;
   logic                         decide;

   always_comb begin
      c_fold = (head_item.in_center && head_item.range_value < cmin_ff) ?
               head_item.range_value : cmin_ff;
      l_fold = (head_item.in_left && head_item.range_value < lmin_ff) ?
               head_item.range_value : lmin_ff;
      r_fold = (head_item.in_right && head_item.range_value < rmin_ff) ?
               head_item.range_value : rmin_ff;

      below_stop = c_fold < cfg.stop_range;
      turn       = below_stop || (c_fold < cfg.safe_range);
      pick_left  = l_fold <= r_fold;

      pop    = head_valid &&
               (!head_item.last_sample || !rsp_valid_ff || rsp_chan.ready);
      decide = pop && head_item.last_sample;
   end

   always_comb begin
      cmin_in         = cmin_ff;
      lmin_in         = lmin_ff;
      rmin_in         = rmin_ff;
      left_choice_in  = left_choice_ff;
      right_choice_in = right_choice_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_in          = rsp_ff;

      if (pop) begin
         cmin_in = c_fold;
         lmin_in = l_fold;
         rmin_in = r_fold;
      end

      if (decide) begin
         cmin_in = '1;
         lmin_in = '1;
         rmin_in = '1;
         if (turn) begin
            left_choice_in  = pick_left;
            right_choice_in = !pick_left;
         end
         rsp_valid_in          = 1'b1;
         rsp_in.keep_moving    = !below_stop;
         rsp_in.drive_forward  = !below_stop;
         rsp_in.turning        = turn;
         rsp_in.turn_left      = left_choice_in;
         rsp_in.turn_right     = right_choice_in;
         rsp_in.center_closest = c_fold;
         rsp_in.left_closest   = l_fold;
         rsp_in.right_closest  = r_fold;
         if (!turn) begin
            rsp_in.turn_direction = lsoa_pkg::DIR_NONE;
         end else if (left_choice_in) begin
            rsp_in.turn_direction = lsoa_pkg::DIR_LEFT;
         end else if (right_choice_in) begin
            rsp_in.turn_direction = lsoa_pkg::DIR_RIGHT;
         end else begin
            rsp_in.turn_direction = lsoa_pkg::DIR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmin_ff         <= '1;
         lmin_ff         <= '1;
         rmin_ff         <= '1;
         left_choice_ff  <= 1'b0;
         right_choice_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cmin_ff         <= cmin_in;
         lmin_ff         <= lmin_in;
         rmin_ff         <= rmin_in;
         left_choice_ff  <= left_choice_in;
         right_choice_ff <= right_choice_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.keep_moving    = rsp_ff.keep_moving;
   assign rsp_chan.turning        = rsp_ff.turning;
   assign rsp_chan.turn_left      = rsp_ff.turn_left;
   assign rsp_chan.turn_right     = rsp_ff.turn_right;
   assign rsp_chan.drive_forward  = rsp_ff.drive_forward;
   assign rsp_chan.turn_direction = rsp_ff.turn_direction;
   assign rsp_chan.center_closest = rsp_ff.center_closest;
   assign rsp_chan.left_closest   = rsp_ff.left_closest;
   assign rsp_chan.right_closest  = rsp_ff.right_closest;

endmodule

### sv/lidar_sector_obstacle_avoider_unit.sv
// Top level of the lidar sector obstacle avoider.
// Throughput: one request per cycle while the response side keeps up.
// Response path: an accepted last-sample request is written into the queue, and the back
// end pops it and loads the output register, unless a held response is not yet taken.
// Reset: synchronous; minimums go to all ones, turn choices clear, registers load defaults.
module lidar_sector_obstacle_avoider_unit (
   input  logic                             clock,
   input  logic                             reset,
   lsoa_req_if.sink                         req_chan,
   lsoa_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [lsoa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsoa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lsoa_pkg::cfg_type  cfg;
   lsoa_pkg::item_type push_item;
   lsoa_pkg::item_type head_item;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               head_valid;

   lsoa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsoa_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   lsoa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (head_valid),
      .head_item (head_item)
   );

   lsoa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
